>>> sv/lfsq_pkg.sv
// ----------------------------------------------------------------------------
// lfsq_pkg
// Shared types and constants for the largest free square finder.
// ----------------------------------------------------------------------------
package lfsq_pkg;

  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int ROWS_REG_W = 13;
  localparam int COLS_REG_W = 11;

  typedef logic [SIZE_W-1:0] sq_size_t;

  localparam sq_size_t SIZE_SAT = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1
  } cfg_reg_t;

  // position flags of one cell word
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_cell;
  } cell_pos_t;

endpackage

>>> sv/largest_free_square_finder_top.sv
// ----------------------------------------------------------------------------
// largest_free_square_finder_top
// Largest free square in a streamed free/obstacle grid (row-major cells).
//
//   channel  direction  handshake            word
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in         in_valid/in_ready    is_free
//   out      out        out_valid/out_ready  best_row, best_col, best_size
//
// One cell word per cycle sustained; the cell register, one line buffer read
// and the size/best logic form a two-register path.
// The last cell of a grid passes the cell register, then the result register.
// A stalled result holds only the last cell of the next grid; other cells
// keep flowing. cfg_ready is always high; a grid_rows or grid_cols write
// restarts the grid. Reset: grid_rows = grid_cols = 1, position and best
// cleared. No clear pass is needed for the line buffer: row 0 never reads it.
// ----------------------------------------------------------------------------
module largest_free_square_finder_top #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lfsq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfsq_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               is_free,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [RW-1:0]                      best_row,
  output logic [CW-1:0]                      best_col,
  output logic [lfsq_pkg::SIZE_W-1:0]        best_size
);

  logic [lfsq_pkg::ROWS_REG_W-1:0] grid_rows;
  logic [lfsq_pkg::COLS_REG_W-1:0] grid_cols;
  logic                            cfg_fire;
  logic                            clear;

  logic [RW:0]   rows_eff;
  logic [CW:0]   cols_eff;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count;
  logic          last_col_in;
  logic          last_row_in;
  logic          in_fire;

  logic                s1_valid;
  logic                s1_free;
  logic [RW-1:0]       s1_row;
  logic [CW-1:0]       s1_col;
  lfsq_pkg::cell_pos_t s1_pos;
  logic                s1_fire;

  lfsq_pkg::sq_size_t  up_data;
  lfsq_pkg::sq_size_t  size;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign clear     = cfg_fire && ((cfg_index == lfsq_pkg::REG_GRID_ROWS) ||
                                  (cfg_index == lfsq_pkg::REG_GRID_COLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= lfsq_pkg::ROWS_REG_W'(1);
      grid_cols <= lfsq_pkg::COLS_REG_W'(1);
    end else if (cfg_fire) begin
      case (cfg_index)
        lfsq_pkg::REG_GRID_ROWS: grid_rows <= cfg_data[lfsq_pkg::ROWS_REG_W-1:0];
        lfsq_pkg::REG_GRID_COLS: grid_cols <= cfg_data[lfsq_pkg::COLS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_rows == '0) begin
      rows_eff = (RW+1)'(1);
    end else if (32'(grid_rows) > MAX_ROWS) begin
      rows_eff = (RW+1)'(MAX_ROWS);
    end else begin
      rows_eff = (RW+1)'(grid_rows);
    end
  end

  always_comb begin
    if (grid_cols == '0) begin
      cols_eff = (CW+1)'(1);
    end else if (32'(grid_cols) > MAX_COLS) begin
      cols_eff = (CW+1)'(MAX_COLS);
    end else begin
      cols_eff = (CW+1)'(grid_cols);
    end
  end

  assign last_col_in = ({1'b0, col_count} == (cols_eff - (CW+1)'(1)));
  assign last_row_in = ({1'b0, row_count} == (rows_eff - (RW+1)'(1)));

  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_fire) begin
      if (last_col_in) begin
        col_count <= '0;
        row_count <= last_row_in ? '0 : row_count + RW'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_free            <= is_free;
      s1_row             <= row_count;
      s1_col             <= col_count;
      s1_pos.first_row   <= (row_count == '0);
      s1_pos.first_col   <= (col_count == '0);
      s1_pos.last_cell   <= last_col_in && last_row_in;
    end
  end

  lfsq_line_mem #(
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_count),
    .wr_en   (s1_fire),
    .wr_addr (s1_col),
    .wr_data (size),
    .rd_data (up_data)
  );

  lfsq_core #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .s1_valid  (s1_valid),
    .s1_free   (s1_free),
    .s1_row    (s1_row),
    .s1_col    (s1_col),
    .pos       (s1_pos),
    .up_data   (up_data),
    .s1_fire   (s1_fire),
    .size      (size),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .best_row  (best_row),
    .best_col  (best_col),
    .best_size (best_size)
  );

endmodule

>>> sv/lfsq_line_mem.sv
// ----------------------------------------------------------------------------
// lfsq_line_mem
// Line buffer of square sizes, one write and one registered read per cycle,
// with write-to-read bypass on a same-address collision.
// ----------------------------------------------------------------------------
module lfsq_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  lfsq_pkg::sq_size_t   wr_data,
  output lfsq_pkg::sq_size_t   rd_data
);

  lfsq_pkg::sq_size_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

>>> sv/lfsq_core.sv
// ----------------------------------------------------------------------------
// lfsq_core
// Per-cell square size, left/diagonal history, best tracking and the
// result register.
// ----------------------------------------------------------------------------
module lfsq_core #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 s1_valid,
  input  logic                 s1_free,
  input  logic [RW-1:0]        s1_row,
  input  logic [CW-1:0]        s1_col,
  input  lfsq_pkg::cell_pos_t  pos,
  input  lfsq_pkg::sq_size_t   up_data,
  output logic                 s1_fire,
  output lfsq_pkg::sq_size_t   size,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RW-1:0]        best_row,
  output logic [CW-1:0]        best_col,
  output lfsq_pkg::sq_size_t   best_size
);

  lfsq_pkg::sq_size_t left_size;
  lfsq_pkg::sq_size_t diag_size;
  lfsq_pkg::sq_size_t best_size_reg;
  logic [RW-1:0]      best_row_reg;
  logic [CW-1:0]      best_col_reg;

  lfsq_pkg::sq_size_t up;
  lfsq_pkg::sq_size_t left;
  lfsq_pkg::sq_size_t diag;
  lfsq_pkg::sq_size_t min_ul;
  lfsq_pkg::sq_size_t min_all;
  logic               better;

  assign up   = pos.first_row ? '0 : up_data;
  assign left = pos.first_col ? '0 : left_size;
  assign diag = (pos.first_row || pos.first_col) ? '0 : diag_size;

  assign min_ul  = (left < up) ? left : up;
  assign min_all = (diag < min_ul) ? diag : min_ul;

  always_comb begin
    if (!s1_free) begin
      size = '0;
    end else if (min_all == lfsq_pkg::SIZE_SAT) begin
      size = lfsq_pkg::SIZE_SAT;
    end else begin
      size = min_all + lfsq_pkg::sq_size_t'(1);
    end
  end

  assign better  = (size > best_size_reg);
  assign s1_fire = s1_valid && (!pos.last_cell || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      left_size     <= '0;
      diag_size     <= '0;
      best_size_reg <= '0;
      best_row_reg  <= '0;
      best_col_reg  <= '0;
    end else if (s1_fire) begin
      if (pos.last_cell) begin
        left_size     <= '0;
        diag_size     <= '0;
        best_size_reg <= '0;
        best_row_reg  <= '0;
        best_col_reg  <= '0;
      end else begin
        left_size <= size;
        diag_size <= up;
        if (better) begin
          best_size_reg <= size;
          best_row_reg  <= s1_row;
          best_col_reg  <= s1_col;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && pos.last_cell) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && pos.last_cell) begin
      if (better) begin
        best_size <= size;
        best_row  <= s1_row;
        best_col  <= s1_col;
      end else begin
        best_size <= best_size_reg;
        best_row  <= best_row_reg;
        best_col  <= best_col_reg;
      end
    end
  end

  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    (!clear && !(s1_fire && pos.last_cell)) |=> (best_size_reg >= $past(best_size_reg)))
    else $error("best size dropped within a grid");

  a_first_col_size: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_free && pos.first_col && !pos.last_cell && !clear) |=>
    (left_size == lfsq_pkg::sq_size_t'(1)))
    else $error("free cell in first column must have size 1");

  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire && pos.last_cell))
    else $error("result raised without a last cell");

endmodule

>>> verif/largest_free_square_finder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_free_square_finder_top_tb
// Streams free/obstacle grids into the square finder and checks every result.
// A line-buffer DP model in the bench predicts the largest free square of
// each grid. Each result word is compared field by field with the oldest
// prediction. Grid size registers are rewritten between phases: zero,
// unmapped index and mid-grid restarts are all covered, with
// random gaps on the cell channel and random stalls on the result channel.
// ----------------------------------------------------------------------------
module largest_free_square_finder_top_tb;

  localparam int MAX_COLS     = 1024;
  localparam int MAX_ROWS     = 4096;
  localparam int LIMIT        = 1_000_000;
  localparam int SETTLE       = 8;
  localparam int RANDOM_CELLS = 860;

  localparam logic [lfsq_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [lfsq_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [11:0]        row;
    logic [9:0]         col;
    lfsq_pkg::sq_size_t size;
  } square_t;

  typedef struct packed {
    logic [lfsq_pkg::CFG_IDX_W-1:0]  idx;
    logic [lfsq_pkg::CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lfsq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lfsq_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            is_free = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [11:0]                     best_row;
  logic [9:0]                      best_col;
  lfsq_pkg::sq_size_t              best_size;

  largest_free_square_finder_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .is_free   (is_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .best_row  (best_row),
    .best_col  (best_col),
    .best_size (best_size)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  bit          free_cells_q[$];
  reg_write_t  reg_write_q[$];
  square_t     best_square_q[$];
  int unsigned cells_queued = 0;
  int unsigned cells_taken = 0;
  int unsigned writes_queued = 0;
  int unsigned writes_taken = 0;
  bit          in_fire = 1'b0;
  bit          cfg_fire = 1'b0;
  bit          no_idle = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  square_t     want_sq;

  // square size model state
  logic [lfsq_pkg::ROWS_REG_W-1:0] rows_reg = 13'd1;
  logic [lfsq_pkg::COLS_REG_W-1:0] cols_reg = 11'd1;
  lfsq_pkg::sq_size_t              line_sz [MAX_COLS];
  lfsq_pkg::sq_size_t              left_sz = '0;
  lfsq_pkg::sq_size_t              diag_sz = '0;
  lfsq_pkg::sq_size_t              best_sz = '0;
  int unsigned                     row_pos = 0;
  int unsigned                     col_pos = 0;
  int unsigned                     best_r = 0;
  int unsigned                     best_c = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic clear_scan();
    left_sz = '0;
    diag_sz = '0;
    best_sz = '0;
    row_pos = 0;
    col_pos = 0;
    best_r  = 0;
    best_c  = 0;
  endtask

  task automatic write_grid_reg(input logic [lfsq_pkg::CFG_IDX_W-1:0] idx,
                                input logic [lfsq_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      lfsq_pkg::REG_GRID_ROWS: begin
        rows_reg = data[lfsq_pkg::ROWS_REG_W-1:0];
        clear_scan();
      end
      lfsq_pkg::REG_GRID_COLS: begin
        cols_reg = data[lfsq_pkg::COLS_REG_W-1:0];
        clear_scan();
      end
      default: ;
    endcase
  endtask

  task automatic scan_cell(input logic cell_free);
    int unsigned        n_rows, n_cols, c, above, lft, dg, m;
    lfsq_pkg::sq_size_t sz;
    square_t            sq;
    n_rows = eff_dim(rows_reg, MAX_ROWS);
    n_cols = eff_dim(cols_reg, MAX_COLS);
    c      = (col_pos < n_cols) ? col_pos : n_cols - 1;
    above  = (row_pos == 0) ? 0 : line_sz[c];
    lft    = (c == 0) ? 0 : left_sz;
    dg     = (row_pos == 0 || c == 0) ? 0 : diag_sz;
    sz     = '0;
    if (cell_free) begin
      m = above;
      if (lft < m) m = lft;
      if (dg < m) m = dg;
      sz = (m >= lfsq_pkg::SIZE_SAT) ? lfsq_pkg::SIZE_SAT : lfsq_pkg::sq_size_t'(m + 1);
    end
    diag_sz    = lfsq_pkg::sq_size_t'(above);
    left_sz    = sz;
    line_sz[c] = sz;
    if (sz > best_sz) begin
      best_sz = sz;
      best_r  = row_pos;
      best_c  = c;
    end
    if (c + 1 >= n_cols) begin
      col_pos = 0;
      if (row_pos + 1 >= n_rows) begin
        sq.row  = best_r[11:0];
        sq.col  = best_c[9:0];
        sq.size = best_sz;
        best_square_q.push_back(sq);
        clear_scan();
      end else begin
        row_pos++;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  // driver: all inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (free_cells_q.size() != 0) begin
          in_valid <= 1'b1;
          is_free  <= free_cells_q.pop_front();
          in_gap   <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (!cfg_valid || cfg_fire) begin
        if (reg_write_q.size() != 0) begin
          cfg_valid             <= 1'b1;
          {cfg_index, cfg_data} <= reg_write_q.pop_front();
        end else begin
          cfg_valid <= 1'b0;
        end
      end
      if (out_hold != 0) begin
        out_ready <= 1'b0;
        out_hold  <= out_hold - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) out_hold <= pick_gap();
      end
    end
  end

  // monitor: handshakes sampled on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_fire  <= 1'b0;
      cfg_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && in_ready;
      cfg_fire <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        write_grid_reg(cfg_index, cfg_data);
        writes_taken++;
      end
      if (in_valid && in_ready) begin
        scan_cell(is_free);
        cells_taken++;
      end
      if (out_valid && out_ready) begin
        if (best_square_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: row %0d col %0d size %0d",
                     best_row, best_col, best_size);
        end else begin
          want_sq = best_square_q.pop_front();
          if (want_sq.row !== best_row || want_sq.col !== best_col ||
              want_sq.size !== best_size) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result word: want row %0d col %0d size %0d, got row %0d col %0d size %0d",
                       want_sq.row, want_sq.col, want_sq.size,
                       best_row, best_col, best_size);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic queue_cells(input int unsigned n, input int unsigned pct_free);
    repeat (n) begin
      free_cells_q.push_back($urandom_range(0, 99) < pct_free);
      cells_queued++;
    end
  endtask

  // pushes bits[n-1:0], msb first, in row-major order
  task automatic queue_bits(input logic [31:0] bits, input int unsigned n);
    for (int i = n - 1; i >= 0; i--) begin
      free_cells_q.push_back(bits[i]);
      cells_queued++;
    end
  endtask

  task automatic settle();
    while (cells_taken != cells_queued || writes_taken != writes_queued ||
           best_square_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [lfsq_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned data);
    reg_write_q.push_back({idx, data[lfsq_pkg::CFG_DATA_W-1:0]});
    writes_queued++;
    while (writes_taken != writes_queued) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_grid(input int unsigned n_rows, input int unsigned n_cols);
    write_reg(lfsq_pkg::REG_GRID_ROWS, n_rows);
    write_reg(lfsq_pkg::REG_GRID_COLS, n_cols);
  endtask

  function automatic int unsigned pick_dim(input int unsigned hi);
    if ($urandom_range(0, 19) == 0) return 0;
    return $urandom_range(1, hi);
  endfunction

  function automatic int unsigned pick_fill();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 50;
      2:       return 85;
      3:       return 95;
      default: return 100;
    endcase
  endfunction

  initial begin
    int unsigned random_cells;
    int unsigned n_cells;
    int unsigned part;
    random_cells = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 1x1 grid out of reset: obstacle, then free
    queue_bits('b01, 2);
    settle();
    // no free cell, then a full 2x2 square
    set_grid(2, 2);
    queue_bits('b0000, 4);
    queue_bits('b1111, 4);
    settle();
    // equal sizes: earliest cell wins
    set_grid(2, 3);
    queue_bits('b101_001, 6);
    settle();
    // zero dimensions act as one
    set_grid(0, 0);
    queue_bits('b1, 1);
    settle();
    // unmapped index leaves the grid in progress alone
    set_grid(2, 2);
    queue_bits('b111, 3);
    settle();
    write_reg(REG_SPARE_3, '1);
    queue_bits('b1, 1);
    settle();
    // a real write drops the partial grid
    queue_bits('b11, 2);
    settle();
    write_reg(lfsq_pkg::REG_GRID_ROWS, 2);
    queue_bits('b1110, 4);
    settle();
    write_reg(REG_SPARE_2, '0);

    while (random_cells < RANDOM_CELLS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 24) == 0) begin
        set_grid(1, pick_dim(16));
      end else if ($urandom_range(0, 5) == 0) begin
        write_reg(lfsq_pkg::REG_GRID_COLS, pick_dim(9));
      end else begin
        set_grid(pick_dim(6), pick_dim(9));
      end
      n_cells = eff_dim(rows_reg, MAX_ROWS) * eff_dim(cols_reg, MAX_COLS);
      repeat ($urandom_range(1, 4)) begin
        queue_cells(n_cells, pick_fill());
        random_cells += n_cells;
      end
      part = $urandom_range(0, n_cells - 1);
      case ($urandom_range(0, 5))
        0: begin
          queue_cells(part, pick_fill());
          settle();
          write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom_range(0, 8191));
          queue_cells(n_cells - part, pick_fill());
          random_cells += n_cells;
        end
        1: begin
          queue_cells(part, pick_fill());
          random_cells += part;
        end
        default: ;
      endcase
      settle();
    end

    no_idle = 1'b0;
    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && best_square_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
